/* sv/psvl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvl_pkg
// Shared constants, the queued transaction type and an index helper for the
// pair sum lookup block.
// ----------------------------------------------------------------------------
package psvl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int NEED_W   = VAL_W + 1;
  localparam int FIELD_W  = 6;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [NEED_W-1:0] need;
    logic              first;
    logic              last;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  function automatic logic [FIELD_W-1:0] idx_field(input logic [IDX_W-1:0] idx);
    logic [IDX_W+FIELD_W-1:0] wide;
    wide = {{FIELD_W{1'b0}}, idx};
    return wide[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/pair_sum_seen_value_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pair_sum_seen_value_lookup
// Streaming two-sum search over the values of one array.
// ----------------------------------------------------------------------------
// Each pushed value is compared against the values already stored for the
// current array; the first array pair that sums to target_sum is reported
// with the position of its newest matching partner. In the back end the
// scan reads the seen-value memory one entry per cycle from the newest entry
// down and stops at the first hit, and it is skipped once the array is
// answered. A two-entry queue lets new transactions be pushed while a search
// runs, and a result register lets the search continue while a finished
// result waits to be popped.
module pair_sum_seen_value_lookup
  import psvl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                target_sum_we,
  input  wire logic [VAL_W-1:0]    target_sum,
  input  wire logic [VAL_W-1:0]    value,
  input  wire logic                first_item,
  input  wire logic                last_item,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                pop,
  output logic                     empty,
  output logic                     match,
  output logic [FIELD_W-1:0]       partner_index,
  output logic [FIELD_W-1:0]       item_index,
  output logic                     none_found,
  output logic                     overflow
);

  q_wr_t q_wr;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  item_t q_item;

  psvl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .target_sum_we (target_sum_we),
    .target_sum    (target_sum),
    .value         (value),
    .first_item    (first_item),
    .last_item     (last_item),
    .push          (push),
    .full          (full),
    .q_full        (q_full),
    .q_wr          (q_wr)
  );

  psvl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  psvl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .match         (match),
    .partner_index (partner_index),
    .item_index    (item_index),
    .none_found    (none_found),
    .overflow      (overflow)
  );

endmodule
`default_nettype wire

/* sv/psvl_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvl_front
// Holds the target sum, accepts input transactions and forms the 33-bit
// difference that the back end searches for.
// ----------------------------------------------------------------------------
module psvl_front
  import psvl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              target_sum_we,
  input  wire logic [VAL_W-1:0]  target_sum,
  input  wire logic [VAL_W-1:0]  value,
  input  wire logic              first_item,
  input  wire logic              last_item,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              q_full,
  output q_wr_t                  q_wr
);

  logic [VAL_W-1:0] target;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (target_sum_we) begin
      target <= target_sum;
    end
  end

  always_comb begin
    full            = q_full;
    q_wr.push       = push && !q_full;
    q_wr.item.value = value;
    q_wr.item.need  = {target[VAL_W-1], target} - {value[VAL_W-1], value};
    q_wr.item.first = first_item;
    q_wr.item.last  = last_item;
  end

endmodule
`default_nettype wire

/* sv/psvl_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvl_queue
// Two-entry queue that decouples the front end from the search back end.
// ----------------------------------------------------------------------------
module psvl_queue
  import psvl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  q_wr_t      q_wr,
  output logic       q_full,
  input  wire logic  q_pop,
  output logic       q_empty,
  output item_t      q_item
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign q_item  = slot[rd_ptr];
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slot[wr_ptr] <= q_wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({q_wr.push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/psvl_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvl_back
// Seen-value memory and search sequencer: scans stored entries newest first,
// one per cycle, stores the value while room is left and registers the result.
// ----------------------------------------------------------------------------
module psvl_back
  import psvl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  item_t                    q_item,
  output logic                     q_pop,
  input  wire logic                pop,
  output logic                     empty,
  output logic                     match,
  output logic [FIELD_W-1:0]       partner_index,
  output logic [FIELD_W-1:0]       item_index,
  output logic                     none_found,
  output logic                     overflow
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data;

  logic [1:0]       state;
  item_t            cur;
  logic [IDX_W-1:0] ptr;
  logic             found;
  logic [IDX_W-1:0] partner;
  logic [CNT_W-1:0] stored_count;
  logic             answered;
  logic             out_valid;

  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_m1;
  logic             ans_eff;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             entry_hit;
  logic             slot_free;
  logic             finish;
  logic             has_room;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] pos;

  always_comb begin
    cnt_eff   = q_item.first ? '0 : stored_count;
    ans_eff   = q_item.first ? 1'b0 : answered;
    cnt_m1    = cnt_eff - CNT_W'(1);
    entry_hit = ({rd_data[VAL_W-1], rd_data} == cur.need);
    slot_free = !out_valid || pop;
    finish    = (state == ST_DONE) && slot_free;
    has_room  = stored_count < CNT_W'(CAPACITY);
    wr_addr   = stored_count[IDX_W-1:0];
    pos       = has_room ? wr_addr : IDX_W'(CAPACITY - 1);
    q_pop     = (state == ST_IDLE) && !q_empty;
    rd_en     = 1'b0;
    rd_addr   = ptr - IDX_W'(1);
    case (state)
      ST_IDLE: begin
        rd_addr = cnt_m1[IDX_W-1:0];
        rd_en   = !q_empty && !ans_eff && (cnt_eff != '0);
      end
      ST_SCAN: begin
        rd_en = !entry_hit && (ptr != '0);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (finish && has_room) begin
      mem[wr_addr] <= cur.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (rd_en) begin
      ptr <= rd_addr;
    end
    if ((state == ST_SCAN) && entry_hit) begin
      partner <= ptr;
    end
    if (finish) begin
      match         <= found;
      partner_index <= found ? idx_field(partner) : '0;
      item_index    <= idx_field(pos);
      none_found    <= cur.last && !(answered || found);
      overflow      <= !has_room;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      found        <= 1'b0;
      stored_count <= '0;
      answered     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            found <= 1'b0;
            if (q_item.first) begin
              stored_count <= '0;
              answered     <= 1'b0;
            end
            state <= rd_en ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (entry_hit) begin
            found <= 1'b1;
            state <= ST_DONE;
          end else if (ptr == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            answered <= answered || found;
            if (has_room) begin
              stored_count <= stored_count + CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (finish) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

endmodule
`default_nettype wire

/* sv/psvl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psvl_checker
// Port-level checks on the result side of the pair sum lookup block.
// ----------------------------------------------------------------------------
module psvl_checker
  import psvl_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               pop,
  input wire logic               empty,
  input wire logic               match,
  input wire logic [FIELD_W-1:0] partner_index,
  input wire logic [FIELD_W-1:0] item_index,
  input wire logic               none_found,
  input wire logic               overflow
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(match) && $stable(partner_index) &&
      $stable(item_index) && $stable(none_found) && $stable(overflow))
    else $error("result changed while stalled");

  a_match_excludes_none: assert property (@(posedge clk) disable iff (rst)
    !empty && match |-> !none_found)
    else $error("match and none_found both set");

  a_partner_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !match |-> partner_index == '0)
    else $error("partner_index nonzero without match");

  a_overflow_index: assert property (@(posedge clk) disable iff (rst)
    !empty && overflow |-> item_index == idx_field(IDX_W'(CAPACITY - 1)))
    else $error("overflow result not at last position");

endmodule

bind pair_sum_seen_value_lookup psvl_checker u_psvl_checker (
  .clk           (clk),
  .rst           (rst),
  .pop           (pop),
  .empty         (empty),
  .match         (match),
  .partner_index (partner_index),
  .item_index    (item_index),
  .none_found    (none_found),
  .overflow      (overflow)
);
`default_nettype wire
